### design/mse_pkg.sv
package mse_pkg;

  // Instruction memory depth is fixed by the 10-bit next_pc field: 256 words.
  localparam int unsigned PC_W   = 8;
  localparam int unsigned XLEN   = 32;
  localparam logic [4:0]  REG_RA = 5'd31;

  typedef enum logic [3:0] {
    KIND_NONE,
    KIND_PRE_REG,
    KIND_PRE_MEM,
    KIND_ALU,
    KIND_LW,
    KIND_SW,
    KIND_BEQ,
    KIND_JMP,
    KIND_ILL
  } kind_e;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_NOR,
    ALU_SLT
  } alu_e;

  // decoded word as it sits in the queue
  typedef struct packed {
    kind_e                kind;
    alu_e                 alu;
    logic [4:0]           rs;
    logic [4:0]           rt;
    logic [4:0]           dst;
    logic                 we;
    logic [15:0]          imm;
    logic [PC_W-1:0]      jidx;
    logic [XLEN-1:0]      lval;
  } dec_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [31:0]          instr_word;
    logic [4:0]           load_index;
    logic signed [31:0]   load_value;
  } in_word_t;

  typedef struct packed {
    logic [9:0]           next_pc;
    logic                 reg_write;
    logic [4:0]           reg_index;
    logic signed [31:0]   reg_value;
    logic                 mem_write;
    logic [4:0]           mem_index;
    logic signed [31:0]   mem_value;
    logic                 branch_taken;
    logic                 illegal;
  } out_word_t;

endpackage

### design/mips_subset_instruction_executor.sv
// Channel  Handshake                 Payload                 Direction
// -------  ------------------------  ----------------------  ---------
// in       in_valid_i / in_ready_o   in_word_i  (in_word_t)  request
// out      out_valid_o / out_ready_i out_word_o (out_word_t) result
//
// One word per cycle when nothing stalls; out_valid_o rises once an accepted word reaches M.
// A word that reads the register loaded by the lw directly ahead of it waits in the queue.
// If DMEM_WORDS is not a power of two, lw and sw hold the back end while mse_dmod runs.
// After reset a clearing pass over max(32, DMEM_WORDS) addresses zeroes the register file
// and data memory; in_ready_o stays low during it.
// A stalled output holds the back end; the queue takes words until both entries are full.
module mips_subset_instruction_executor #(
  parameter int unsigned DMEM_WORDS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mse_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mse_pkg::out_word_t out_word_o
);

  logic          push, full, pop, h_vld, busy;
  mse_pkg::dec_t dec, h_dec;

  // decode and admit words into the queue
  mse_front u_front (
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .full_i     (full),
    .busy_i     (busy),
    .in_ready_o (in_ready_o),
    .push_o     (push),
    .dec_o      (dec)
  );

  // two-entry queue decouples front and back
  mse_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (dec),
    .full_o (full),
    .pop_i  (pop),
    .vld_o  (h_vld),
    .data_o (h_dec)
  );

  // pc, register file, data memory, execute and result register
  mse_back #(.DMEM_WORDS(DMEM_WORDS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .h_vld_i     (h_vld),
    .h_dec_i     (h_dec),
    .pop_o       (pop),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

### design/mse_front.sv
module mse_front (
  input  logic              in_valid_i,
  input  mse_pkg::in_word_t in_word_i,
  input  logic              full_i,
  input  logic              busy_i,
  output logic              in_ready_o,
  output logic              push_o,
  output mse_pkg::dec_t     dec_o
);

  localparam logic [1:0] REQ_EXEC    = 2'd0;
  localparam logic [1:0] REQ_PRE_REG = 2'd1;
  localparam logic [1:0] REQ_PRE_MEM = 2'd2;

  localparam logic [5:0] OP_RTYPE = 6'b000000;
  localparam logic [5:0] OP_LW    = 6'b100011;
  localparam logic [5:0] OP_SW    = 6'b101011;
  localparam logic [5:0] OP_BEQ   = 6'b000100;
  localparam logic [5:0] OP_J     = 6'b000010;
  localparam logic [5:0] OP_JAL   = 6'b000011;

  localparam logic [5:0] FN_ADD = 6'b100000;
  localparam logic [5:0] FN_SUB = 6'b100010;
  localparam logic [5:0] FN_AND = 6'b100100;
  localparam logic [5:0] FN_OR  = 6'b100101;
  localparam logic [5:0] FN_SLT = 6'b101010;
  localparam logic [5:0] FN_NOR = 6'b100111;

  logic [31:0] iw;
  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rd;

  assign in_ready_o = !full_i && !busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  assign iw = in_word_i.instr_word;
  assign op = iw[31:26];
  assign fn = iw[5:0];
  assign rd = iw[15:11];

  always_comb begin
    dec_o      = '0;
    dec_o.kind = mse_pkg::KIND_NONE;
    dec_o.alu  = mse_pkg::ALU_ADD;
    dec_o.imm  = iw[15:0];
    dec_o.jidx = iw[mse_pkg::PC_W-1:0];
    dec_o.lval = in_word_i.load_value;
    unique case (in_word_i.req_type)
      REQ_PRE_REG: begin
        dec_o.kind = mse_pkg::KIND_PRE_REG;
        dec_o.dst  = in_word_i.load_index;
        dec_o.we   = (in_word_i.load_index != 5'd0);
      end
      REQ_PRE_MEM: begin
        dec_o.kind = mse_pkg::KIND_PRE_MEM;
        dec_o.dst  = in_word_i.load_index;
      end
      REQ_EXEC: begin
        dec_o.rs = iw[25:21];
        dec_o.rt = iw[20:16];
        unique case (op)
          OP_RTYPE: begin
            dec_o.kind = mse_pkg::KIND_ALU;
            dec_o.dst  = rd;
            dec_o.we   = (rd != 5'd0);
            unique case (fn)
              FN_ADD:  dec_o.alu = mse_pkg::ALU_ADD;
              FN_SUB:  dec_o.alu = mse_pkg::ALU_SUB;
              FN_AND:  dec_o.alu = mse_pkg::ALU_AND;
              FN_OR:   dec_o.alu = mse_pkg::ALU_OR;
              FN_NOR:  dec_o.alu = mse_pkg::ALU_NOR;
              FN_SLT:  dec_o.alu = mse_pkg::ALU_SLT;
              default: begin
                dec_o.kind = mse_pkg::KIND_ILL;
                dec_o.we   = 1'b0;
              end
            endcase
          end
          OP_LW: begin
            dec_o.kind = mse_pkg::KIND_LW;
            dec_o.dst  = iw[20:16];
            dec_o.we   = (iw[20:16] != 5'd0);
          end
          OP_SW:  dec_o.kind = mse_pkg::KIND_SW;
          OP_BEQ: dec_o.kind = mse_pkg::KIND_BEQ;
          OP_J:   dec_o.kind = mse_pkg::KIND_JMP;
          OP_JAL: begin
            dec_o.kind = mse_pkg::KIND_JMP;
            dec_o.dst  = mse_pkg::REG_RA;
            dec_o.we   = 1'b1;
          end
          default: dec_o.kind = mse_pkg::KIND_ILL;
        endcase
      end
      default: dec_o.kind = mse_pkg::KIND_NONE;
    endcase
  end

endmodule

### design/mse_fifo.sv
module mse_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mse_pkg::dec_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          vld_o,
  output mse_pkg::dec_t data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);

  mse_pkg::dec_t ent_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;

  assign full_o = (cnt_q == (PW+1)'(DEPTH));
  assign vld_o  = (cnt_q != '0);
  assign data_o = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### design/mse_dmod.sv
// Data word index: (byte address >> 2) mod DMEM_WORDS.
// Power-of-two depth is a bit-select; otherwise a reciprocal multiply gives
// the registered quotient and the remainder follows from its low bits in
// the next cycle.
module mse_dmod #(
  parameter int unsigned DMEM_WORDS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_i,
  input  logic                          consume_i,
  input  logic [29:0]                   word_i,
  output logic                          ok_o,
  output logic [$clog2(DMEM_WORDS)-1:0] idx_o
);

  localparam int unsigned AW   = $clog2(DMEM_WORDS);
  localparam bit          POW2 = ((1 << AW) == DMEM_WORDS);

  if (POW2) begin : g_pow2
    assign ok_o  = 1'b1;
    assign idx_o = word_i[AW-1:0];
  end else begin : g_recip
    localparam int unsigned   NB    = 30;
    localparam int unsigned   MW    = NB + 1;
    localparam int unsigned   SH    = NB + AW;
    // ceil(2^SH / DMEM_WORDS): exact quotient for every 30-bit word address
    localparam logic [63:0]   MUL64 = ((64'd1 << SH) + 64'(DMEM_WORDS - 1)) /
                                      64'(DMEM_WORDS);
    localparam logic [MW-1:0] MUL   = MUL64[MW-1:0];
    localparam logic [AW-1:0] DLO   = AW'(DMEM_WORDS);

    logic [NB-1:0]    word_q, quo_q;
    logic [AW-1:0]    rem_q, qd;
    logic [NB+MW-1:0] prod;
    logic             busy_q, fin_q, start;

    assign start = req_i && !busy_q && !fin_q;
    assign prod  = {{MW{1'b0}}, word_i} * {{NB{1'b0}}, MUL};
    // remainder is below 2^AW, so only the low bits of q*D matter
    assign qd    = quo_q[AW-1:0] * DLO;
    assign ok_o  = fin_q;
    assign idx_o = rem_q;

    always_ff @(posedge clk_i) begin
      if (start) begin
        word_q <= word_i;
        quo_q  <= NB'(prod >> SH);
      end
      if (busy_q) begin
        rem_q <= word_q[AW-1:0] - qd;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b0;
      end else begin
        if (consume_i) fin_q <= 1'b0;
        if (start) begin
          busy_q <= 1'b1;
        end else if (busy_q) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

endmodule

### design/mse_back.sv
// Back end: operand read (X entry), execute + data memory (X), result (M).
module mse_back #(
  parameter int unsigned DMEM_WORDS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               h_vld_i,
  input  mse_pkg::dec_t      h_dec_i,
  output logic               pop_o,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mse_pkg::out_word_t out_word_o
);

  localparam int unsigned AW    = $clog2(DMEM_WORDS);
  localparam int unsigned CLR_N = (DMEM_WORDS > 32) ? DMEM_WORDS : 32;
  localparam int unsigned CW    = $clog2(CLR_N);
  localparam int unsigned PW    = mse_pkg::PC_W;
  localparam int unsigned XL    = mse_pkg::XLEN;

  // clearing sweep
  logic          clr_q;
  logic [CW-1:0] clr_cnt_q;
  logic          clr_rf, clr_dm;

  // X stage
  logic          x_vld_q;
  mse_pkg::dec_t x_dec_q;
  logic          byp_a_q, byp_b_q;
  logic [XL-1:0] fwd_a_q, fwd_b_q, rf_a_q, rf_b_q;
  logic [PW-1:0] pc_q;

  // M stage
  logic          m_vld_q, m_we_q, m_lw_q, m_mwe_q, m_br_q, m_ill_q;
  logic [4:0]    m_dst_q, m_midx_q;
  logic [XL-1:0] m_val_q, m_mval_q, dm_q;
  logic [PW-1:0] m_npc_q;

  logic [XL-1:0] rf_mem [32];
  logic [XL-1:0] dm_mem [DMEM_WORDS];

  logic [XL-1:0] a, b, simm, ea, alu_res, link, x_wval, x_mval, m_wval;
  logic [PW-1:0] seq, br_tgt, x_npc;
  logic [8:0]    lnk9;
  logic          x_br, x_ill, x_mwe, x_mem, x_is_lw;
  logic [AW-1:0] x_midx, pidx, dm_idx;
  logic [10:0]   pr;
  logic          dm_ok, adv, x_ok, x_go, take, lu;
  logic          hit_xa, hit_xb, hit_ma, hit_mb;
  logic          rf_we, dm_we, m_fire;
  logic [4:0]    rf_wa;
  logic [XL-1:0] rf_wd, dm_wd;
  logic [AW-1:0] dm_wa;

  mse_dmod #(.DMEM_WORDS(DMEM_WORDS)) u_dmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (x_vld_q && x_mem),
    .consume_i (x_go),
    .word_i    (ea[31:2]),
    .ok_o      (dm_ok),
    .idx_o     (dm_idx)
  );

  // ---- execute ----
  assign a    = byp_a_q ? fwd_a_q : rf_a_q;
  assign b    = byp_b_q ? fwd_b_q : rf_b_q;
  assign simm = {{16{x_dec_q.imm[15]}}, x_dec_q.imm};
  assign ea   = a + simm;
  assign seq  = pc_q + 1'b1;
  assign br_tgt = pc_q + 1'b1 + simm[PW-1:0];
  assign lnk9 = {1'b0, pc_q} + 9'd1;
  assign link = {{(XL-11){1'b0}}, lnk9, 2'b00};
  assign x_is_lw = (x_dec_q.kind == mse_pkg::KIND_LW);

  always_comb begin
    unique case (x_dec_q.alu)
      mse_pkg::ALU_ADD: alu_res = a + b;
      mse_pkg::ALU_SUB: alu_res = a - b;
      mse_pkg::ALU_AND: alu_res = a & b;
      mse_pkg::ALU_OR:  alu_res = a | b;
      mse_pkg::ALU_NOR: alu_res = ~(a | b);
      mse_pkg::ALU_SLT: alu_res = {{(XL-1){1'b0}}, ($signed(a) < $signed(b))};
      default:          alu_res = '0;
    endcase
  end

  // preload word index: load_index less DMEM_WORDS at most four times (mod DMEM_WORDS when DMEM_WORDS >= 7)
  always_comb begin
    pr = {6'b0, x_dec_q.dst};
    for (int i = 0; i < 4; i++) begin
      if (pr >= 11'(DMEM_WORDS)) pr = pr - 11'(DMEM_WORDS);
    end
    pidx = AW'(pr);
  end

  always_comb begin
    x_npc  = pc_q;
    x_wval = '0;
    x_br   = 1'b0;
    x_ill  = 1'b0;
    x_mwe  = 1'b0;
    x_mem  = 1'b0;
    x_midx = pidx;
    x_mval = '0;
    unique case (x_dec_q.kind)
      mse_pkg::KIND_PRE_REG: x_wval = x_dec_q.lval;
      mse_pkg::KIND_PRE_MEM: begin
        x_mwe  = 1'b1;
        x_mval = x_dec_q.lval;
      end
      mse_pkg::KIND_ALU: begin
        x_wval = alu_res;
        x_npc  = seq;
      end
      mse_pkg::KIND_LW: begin
        x_mem  = 1'b1;
        x_midx = dm_idx;
        x_npc  = seq;
      end
      mse_pkg::KIND_SW: begin
        x_mem  = 1'b1;
        x_mwe  = 1'b1;
        x_midx = dm_idx;
        x_mval = b;
        x_npc  = seq;
      end
      mse_pkg::KIND_BEQ: begin
        if (a == b) begin
          x_npc = br_tgt;
          x_br  = 1'b1;
        end else begin
          x_npc = seq;
        end
      end
      mse_pkg::KIND_JMP: begin
        x_npc  = x_dec_q.jidx;
        x_br   = 1'b1;
        x_wval = link;
      end
      mse_pkg::KIND_ILL: x_ill = 1'b1;
      default: x_npc = pc_q;
    endcase
  end

  // ---- pipeline control ----
  assign m_fire = m_vld_q && out_ready_i;
  assign adv    = !m_vld_q || out_ready_i;
  assign x_ok   = !(x_vld_q && x_mem) || dm_ok;
  assign x_go   = adv && x_ok && !clr_q;
  // load result comes from dm_q in M, too late for X: hold a dependent word back while the lw is in X
  assign lu     = x_vld_q && x_is_lw && x_dec_q.we &&
                  (x_dec_q.dst == h_dec_i.rs || x_dec_q.dst == h_dec_i.rt);
  assign take   = x_go && h_vld_i && !lu;
  assign pop_o  = take;
  assign busy_o = clr_q;

  assign m_wval = m_lw_q ? dm_q : m_val_q;

  // forwarding: X result is newer than M
  assign hit_xa = x_vld_q && x_dec_q.we && !x_is_lw && (x_dec_q.dst == h_dec_i.rs);
  assign hit_xb = x_vld_q && x_dec_q.we && !x_is_lw && (x_dec_q.dst == h_dec_i.rt);
  assign hit_ma = m_vld_q && m_we_q && (m_dst_q == h_dec_i.rs);
  assign hit_mb = m_vld_q && m_we_q && (m_dst_q == h_dec_i.rt);

  // ---- storage write ports ----
  assign clr_rf = ((clr_cnt_q >> 5) == '0);
  assign clr_dm = ({1'b0, clr_cnt_q} < (CW+1)'(DMEM_WORDS));

  always_comb begin
    if (clr_q) begin
      rf_we = clr_rf;
      rf_wa = clr_cnt_q[4:0];
      rf_wd = '0;
      dm_we = clr_dm;
      dm_wa = clr_cnt_q[AW-1:0];
      dm_wd = '0;
    end else begin
      rf_we = m_fire && m_we_q;
      rf_wa = m_dst_q;
      rf_wd = m_wval;
      dm_we = x_go && x_vld_q && x_mwe;
      dm_wa = x_midx;
      dm_wd = x_mval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (take) begin
      rf_a_q <= rf_mem[h_dec_i.rs];
      rf_b_q <= rf_mem[h_dec_i.rt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) dm_mem[dm_wa] <= dm_wd;
    if (x_go && x_vld_q) dm_q <= dm_mem[x_midx];
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (take) begin
      x_dec_q <= h_dec_i;
      byp_a_q <= hit_xa || hit_ma;
      byp_b_q <= hit_xb || hit_mb;
      fwd_a_q <= hit_xa ? x_wval : m_wval;
      fwd_b_q <= hit_xb ? x_wval : m_wval;
    end
    if (x_go && x_vld_q) begin
      m_npc_q  <= x_npc;
      m_we_q   <= x_dec_q.we;
      m_dst_q  <= x_dec_q.dst;
      m_val_q  <= x_wval;
      m_lw_q   <= x_is_lw;
      m_mwe_q  <= x_mwe;
      m_midx_q <= 5'(x_midx);
      m_mval_q <= x_mval;
      m_br_q   <= x_br;
      m_ill_q  <= x_ill;
    end
  end

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      x_vld_q   <= 1'b0;
      m_vld_q   <= 1'b0;
      pc_q      <= '0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == CW'(CLR_N - 1)) clr_q <= 1'b0;
      end
      if (x_go) begin
        x_vld_q <= take;
        m_vld_q <= x_vld_q;
        if (x_vld_q) pc_q <= x_npc;
      end else if (adv) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // ---- result word ----
  assign out_valid_o = m_vld_q;

  always_comb begin
    out_word_o              = '0;
    out_word_o.next_pc      = {m_npc_q, 2'b00};
    out_word_o.reg_write    = m_we_q;
    out_word_o.reg_index    = m_we_q ? m_dst_q : 5'd0;
    out_word_o.reg_value    = m_we_q ? m_wval : '0;
    out_word_o.mem_write    = m_mwe_q;
    out_word_o.mem_index    = m_mwe_q ? m_midx_q : 5'd0;
    out_word_o.mem_value    = m_mwe_q ? m_mval_q : '0;
    out_word_o.branch_taken = m_br_q;
    out_word_o.illegal      = m_ill_q;
  end

endmodule
